>>> hdl/float_to_scaled_decimal_defines.svh
// Assertion macros for the float to scaled decimal block.
`ifndef FLOAT_TO_SCALED_DECIMAL_DEFINES_SVH
`define FLOAT_TO_SCALED_DECIMAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define F2SD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("f2sd check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define F2SD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("f2sd check failed");

`endif

>>> hdl/f2sd_pkg.sv
`default_nettype none
package f2sd_pkg;
  localparam int WB = 176;          // working width, covers 10^7 * 2^149
  localparam int CW = 96;           // coefficient width
  localparam int QW = 24;           // quotient bits in the reduce path
  localparam int MAX_SCALE = 28;
  localparam logic [WB-1:0] LOW_TARGET = WB'(1000000);
  localparam logic [WB-1:0] HIGH_LIMIT = WB'(10000000);

  typedef logic [WB-1:0] word_t;
endpackage
`default_nettype wire

>>> hdl/float_to_scaled_decimal.sv
`default_nettype none
// float_to_scaled_decimal: IEEE single -> 96-bit decimal coefficient, sign, scale.
// Input: pulse start with float_bits while busy is low; the transfer happens
// at that edge and busy rises on the next cycle until the result is out.
// Output: done is high for exactly one cycle with coef_word0..2, negative,
// scale and status. The receiver cannot stall; it must take the result then.
// status=1 marks NaN, infinity, too large or too small (all fields zero).
// Steps, from the accepting edge to done (LOAD first on every path):
//   values with fraction bits (scale-up path): up to s <= 28 steps of the
//     times-ten adder in SMUL, one rounding step, then SSHF;
//   integers of 1e7 or more: CHKBIG, then c <= 22 decades found in BFIND
//     with the times-ten adders, 24 restoring divide steps in BDIV, a clear
//     step and 24 shift-add steps in BMUL, then BFIX;
//   NaN/infinity finish in LOAD; oversize integers and integers below 1e7 in CHKBIG.
// One item is in flight at a time; busy is already low while done is high, so
// the next item may be transferred at the edge that ends the done cycle.
// Synchronous reset returns to idle with done low; an item in flight at reset
// is dropped and gives no done pulse.
module float_to_scaled_decimal
  import f2sd_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [31:0] float_bits,
  output logic        done,
  output logic [31:0] coef_word0,
  output logic [31:0] coef_word1,
  output logic [31:0] coef_word2,
  output logic        negative,
  output logic [4:0]  scale,
  output logic        status
);

  typedef enum logic [3:0] {
    IDLE, LOAD, CHKBIG, SMUL, SSHF, BFIND, BDIV, BMUL, BFIX
  } state_t;

  state_t      state;
  logic [31:0] fbits;
  word_t       acc;     // value N, then dividend, then product
  word_t       rlow;    // low target / decade limit / shifted divisor
  word_t       pw;      // 2^k, or power of ten p
  logic [7:0]  k;
  logic [4:0]  sc;
  logic [4:0]  cnt;
  logic [QW-1:0] q;

  word_t acc_x10, rlow_x10, pw_x10;
  logic  ge;

  // times-ten adders, one per register
  f2sd_mul10 u_mul_acc  (.x(acc),  .y(acc_x10));
  f2sd_mul10 u_mul_lim  (.x(rlow), .y(rlow_x10));
  f2sd_mul10 u_mul_pow  (.x(pw),   .y(pw_x10));

  assign ge   = (acc >= rlow);
  assign busy = (state != IDLE);

  logic [7:0]  ef;
  logic [23:0] mant;
  assign ef   = fbits[30:23];
  assign mant = (ef == 8'd0) ? {1'b0, fbits[22:0]} : {1'b1, fbits[22:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            fbits <= float_bits;
            state <= LOAD;
          end
        end
        LOAD: begin
          sc <= '0;
          if (ef == 8'hFF) begin
            // NaN or infinity
            coef_word0 <= '0; coef_word1 <= '0; coef_word2 <= '0;
            negative <= 1'b0; scale <= '0; status <= 1'b1;
            done <= 1'b1; state <= IDLE;
          end else if (ef >= 8'd150) begin
            // integer value: m << e, e <= 104
            acc   <= WB'(mant) << (ef - 8'd150);
            state <= CHKBIG;
          end else begin
            k     <= (ef == 8'd0) ? 8'd149 : (8'd150 - ef);
            acc   <= WB'(mant);
            rlow  <= LOW_TARGET << ((ef == 8'd0) ? 8'd149 : (8'd150 - ef));
            pw    <= WB'(1) << ((ef == 8'd0) ? 8'd149 : (8'd150 - ef));
            state <= SMUL;
          end
        end
        CHKBIG: begin
          if (acc[WB-1:CW] != '0) begin
            coef_word0 <= '0; coef_word1 <= '0; coef_word2 <= '0;
            negative <= 1'b0; scale <= '0; status <= 1'b1;
            done <= 1'b1; state <= IDLE;
          end else if (acc < HIGH_LIMIT) begin
            coef_word0 <= acc[31:0]; coef_word1 <= acc[63:32]; coef_word2 <= acc[95:64];
            negative <= fbits[31]; scale <= '0; status <= 1'b0;
            done <= 1'b1; state <= IDLE;
          end else begin
            rlow  <= HIGH_LIMIT;
            pw    <= WB'(1);
            state <= BFIND;
          end
        end
        SMUL: begin
          if (!ge && sc != 5'(MAX_SCALE)) begin
            acc <= acc_x10;
            sc  <= sc + 5'd1;
          end else if (sc == 5'(MAX_SCALE) && acc < pw) begin
            // below 1e-28, zero included
            coef_word0 <= '0; coef_word1 <= '0; coef_word2 <= '0;
            negative <= 1'b0; scale <= '0; status <= 1'b1;
            done <= 1'b1; state <= IDLE;
          end else begin
            acc   <= acc + (pw >> 1);   // half an output unit
            state <= SSHF;
          end
        end
        SSHF: begin
          coef_word0 <= 32'(acc >> k);
          coef_word1 <= 32'(acc >> (k + 8'd32));
          coef_word2 <= 32'(acc >> (k + 8'd64));
          negative <= fbits[31]; scale <= sc; status <= 1'b0;
          done <= 1'b1; state <= IDLE;
        end
        BFIND: begin
          if (ge) begin
            rlow <= rlow_x10;
            pw   <= pw_x10;
          end else begin
            // round half up: (2N + p) / (2p)
            acc   <= {acc[WB-2:0], 1'b0} + pw;
            rlow  <= pw << QW;
            q     <= '0;
            cnt   <= 5'(QW);
            state <= BDIV;
          end
        end
        BDIV: begin
          if (ge) begin
            acc <= acc - rlow;
            q   <= {q[QW-2:0], 1'b1};
          end else begin
            q   <= {q[QW-2:0], 1'b0};
          end
          rlow <= rlow >> 1;
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            state <= BMUL;
          end
        end
        BMUL: begin
          if (cnt == '0) begin
            acc <= '0;
            cnt <= 5'(QW);
          end else begin
            acc <= {acc[WB-2:0], 1'b0} + (q[QW-1] ? pw : '0);
            q   <= {q[QW-2:0], 1'b0};
            cnt <= cnt - 5'd1;
            if (cnt == 5'd1) begin
              state <= BFIX;
            end
          end
        end
        BFIX: begin
          // clamp: one step of p less when the product leaves 96 bits
          if (acc[WB-1:CW] != '0) begin
            coef_word0 <= 32'(acc - pw);
            coef_word1 <= 32'((acc - pw) >> 32);
            coef_word2 <= 32'((acc - pw) >> 64);
          end else begin
            coef_word0 <= acc[31:0]; coef_word1 <= acc[63:32]; coef_word2 <= acc[95:64];
          end
          negative <= fbits[31]; scale <= '0; status <= 1'b0;
          done <= 1'b1; state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

`include "float_to_scaled_decimal_defines.svh"

  `F2SD_ASSERT_NOW(a_done_idle, done, !busy)
  `F2SD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `F2SD_ASSERT_NOW(a_err_zero, done && status, (coef_word0 == '0) && (coef_word1 == '0) && ((coef_word2 == '0) && !negative && (scale == '0)))
  `F2SD_ASSERT_NOW(a_scale_range, done && !status, scale <= 5'(MAX_SCALE))

endmodule
`default_nettype wire

>>> hdl/f2sd_mul10.sv
`default_nettype none
module f2sd_mul10
  import f2sd_pkg::*;
(
  input  wire  word_t x,
  output word_t       y
);
  // x*10 = x*8 + x*2
  assign y = {x[WB-4:0], 3'b000} + {x[WB-2:0], 1'b0};
endmodule
`default_nettype wire
